FILE: rtl/core/dea_pkg.sv
package dea_pkg;

	// input mode codes
	localparam logic [3:0] MODE_ADD_LAST     = 4'd0;
	localparam logic [3:0] MODE_ADD_FIRST    = 4'd1;
	localparam logic [3:0] MODE_REMOVE_LAST  = 4'd2;
	localparam logic [3:0] MODE_REMOVE_FIRST = 4'd3;
	localparam logic [3:0] MODE_GET          = 4'd4;
	localparam logic [3:0] MODE_SET          = 4'd5;
	localparam logic [3:0] MODE_CONTAINS     = 4'd6;
	localparam logic [3:0] MODE_GET_FIRST    = 4'd7;
	localparam logic [3:0] MODE_GET_LAST     = 4'd8;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;
	localparam logic [1:0] STATUS_RANGE = 2'd3;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;

	typedef enum logic [3:0] {
		OP_ADD_LAST,
		OP_ADD_FIRST,
		OP_REMOVE_LAST,
		OP_REMOVE_FIRST,
		OP_GET,
		OP_SET,
		OP_CONTAINS,
		OP_GET_FIRST,
		OP_GET_LAST,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  position;
	} cmd_t;

endpackage

FILE: rtl/core/dea_ram.sv
module dea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/dea_front.sv
module dea_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  mode,
	input  logic signed [31:0]          value,
	input  logic [7:0]                  position,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output dea_pkg::cmd_t               cmd
);

	dea_pkg::cmd_t entry_q [2];
	dea_pkg::cmd_t dec;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	logic          pop;

	always_comb begin
		dec.value    = value;
		dec.position = position;
		unique case (mode)
			dea_pkg::MODE_ADD_LAST:     dec.op = dea_pkg::OP_ADD_LAST;
			dea_pkg::MODE_ADD_FIRST:    dec.op = dea_pkg::OP_ADD_FIRST;
			dea_pkg::MODE_REMOVE_LAST:  dec.op = dea_pkg::OP_REMOVE_LAST;
			dea_pkg::MODE_REMOVE_FIRST: dec.op = dea_pkg::OP_REMOVE_FIRST;
			dea_pkg::MODE_GET:          dec.op = dea_pkg::OP_GET;
			dea_pkg::MODE_SET:          dec.op = dea_pkg::OP_SET;
			dea_pkg::MODE_CONTAINS:     dec.op = dea_pkg::OP_CONTAINS;
			dea_pkg::MODE_GET_FIRST:    dec.op = dea_pkg::OP_GET_FIRST;
			dea_pkg::MODE_GET_LAST:     dec.op = dea_pkg::OP_GET_LAST;
			default:                    dec.op = dea_pkg::OP_NOP;
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

endmodule

FILE: rtl/core/dea_back.sv
module dea_back #(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dea_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_data,
	output logic               found,
	output logic [8:0]         element_count,
	output logic [1:0]         status
);

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > dea_pkg::POS_W) ? CW : dea_pkg::POS_W;
	localparam int SW = LW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	state_t         state_q, state_d;
	logic [PW-1:0]  front_q, front_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  scan_idx_q, scan_idx_d;
	logic [PW-1:0]  scan_slot_q, scan_slot_d;
	logic           pend_s1, pend_d;
	logic           hit_q, hit_d;
	dea_pkg::cmd_t  cur_q;

	logic           out_valid_q;
	logic [31:0]    rd_q;
	logic           found_q;
	logic [CW-1:0]  count_out_q;
	logic [1:0]     status_q;

	logic           out_free;
	logic           out_load;
	logic [31:0]    rd_d;
	logic           found_d;
	logic [1:0]     status_d;

	logic           ram_we;
	logic [PW-1:0]  ram_waddr;
	logic [31:0]    ram_wdata;
	logic           ram_re;
	logic [PW-1:0]  ram_raddr;
	logic [31:0]    ram_rdata;

	logic           full;
	logic           empty;
	logic           pos_oor;
	logic [PW-1:0]  front_dec;
	logic [PW-1:0]  front_inc;
	logic [CW+8:0]  count_ext;

	// circular slot of a logical index, sum stays below twice the capacity
	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
		input logic [LW-1:0] logical);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(logical);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		return sum[PW-1:0];
	endfunction

	dea_ram #(
		.WIDTH(dea_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_oor   = (LW'(cmd.position) >= LW'(count_q));
	assign front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - PW'(1);
	assign front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + PW'(1);

	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		count_d     = count_q;
		scan_idx_d  = scan_idx_q;
		scan_slot_d = scan_slot_q;
		pend_d      = 1'b0;
		hit_d       = hit_q;
		cmd_ready   = 1'b0;
		out_load    = 1'b0;
		rd_d        = '0;
		found_d     = 1'b0;
		status_d    = dea_pkg::STATUS_OK;
		ram_we      = 1'b0;
		ram_waddr   = slot_of(front_q, LW'(count_q));
		ram_wdata   = cmd.value;
		ram_re      = 1'b0;
		ram_raddr   = slot_of(front_q, LW'(cmd.position));

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_ready = 1'b1;
					case (cmd.op)
						dea_pkg::OP_ADD_LAST: begin
							out_load = 1'b1;
							if (full) begin
								status_d = dea_pkg::STATUS_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						dea_pkg::OP_ADD_FIRST: begin
							out_load = 1'b1;
							if (full) begin
								status_d = dea_pkg::STATUS_FULL;
							end else begin
								front_d   = front_dec;
								ram_we    = 1'b1;
								ram_waddr = front_dec;
								count_d   = count_q + CW'(1);
							end
						end
						dea_pkg::OP_REMOVE_LAST: begin
							out_load = 1'b1;
							if (empty) begin
								status_d = dea_pkg::STATUS_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						dea_pkg::OP_REMOVE_FIRST: begin
							out_load = 1'b1;
							if (empty) begin
								status_d = dea_pkg::STATUS_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - CW'(1);
							end
						end
						dea_pkg::OP_GET: begin
							if (pos_oor) begin
								out_load = 1'b1;
								status_d = dea_pkg::STATUS_RANGE;
							end else begin
								ram_re  = 1'b1;
								state_d = S_READ;
							end
						end
						dea_pkg::OP_SET: begin
							out_load = 1'b1;
							if (pos_oor) begin
								status_d = dea_pkg::STATUS_RANGE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = slot_of(front_q, LW'(cmd.position));
							end
						end
						dea_pkg::OP_CONTAINS: begin
							if (empty) begin
								out_load = 1'b1;
							end else begin
								scan_idx_d  = '0;
								scan_slot_d = front_q;
								state_d     = S_SCAN;
							end
						end
						dea_pkg::OP_GET_FIRST: begin
							if (empty) begin
								out_load = 1'b1;
								status_d = dea_pkg::STATUS_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								state_d   = S_READ;
							end
						end
						dea_pkg::OP_GET_LAST: begin
							if (empty) begin
								out_load = 1'b1;
								status_d = dea_pkg::STATUS_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = slot_of(front_q, LW'(count_q - CW'(1)));
								state_d   = S_READ;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					rd_d     = ram_rdata;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// issue one read a cycle, compare the word read the cycle before
				if (scan_idx_q < count_q) begin
					ram_re      = 1'b1;
					ram_raddr   = scan_slot_q;
					scan_idx_d  = scan_idx_q + CW'(1);
					scan_slot_d = (scan_slot_q == PW'(CAPACITY - 1)) ? '0
						: scan_slot_q + PW'(1);
					pend_d      = 1'b1;
				end
				if (pend_s1 && (ram_rdata == cur_q.value)) begin
					hit_d   = 1'b1;
					pend_d  = 1'b0;
					state_d = S_DONE;
				end else if (!pend_s1 && (scan_idx_q >= count_q)) begin
					hit_d   = 1'b0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					found_d  = hit_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			scan_idx_q  <= '0;
			scan_slot_q <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rd_q        <= '0;
			found_q     <= 1'b0;
			count_out_q <= '0;
			status_q    <= dea_pkg::STATUS_OK;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			scan_idx_q  <= scan_idx_d;
			scan_slot_q <= scan_slot_d;
			pend_s1     <= pend_d;
			hit_q       <= hit_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				rd_q        <= rd_d;
				found_q     <= found_d;
				count_out_q <= count_d;
				status_q    <= status_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready) begin
			cur_q <= cmd;
		end
	end

	// count is reported modulo 512
	assign count_ext     = (CW + 9)'(count_out_q);
	assign out_valid     = out_valid_q;
	assign read_data     = rd_q;
	assign found         = found_q;
	assign element_count = count_ext[8:0];
	assign status        = status_q;

endmodule

FILE: rtl/core/double_ended_array_store_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_ready  | mode, value, position
// output   | out_valid / out_ready| read_data, found, element_count, status
//
// add, remove, set and unused modes: answered from the idle state of the back end.
// get, get_first, get_last: a read state for the registered read of the store, unless out of range or empty.
// contains: a scan state, one store read a cycle, stopping at the first match.
// reset clears pointer, count and queues; the store itself is not cleared.
// a two-entry command queue takes input while the back end or output stalls.
module double_ended_array_store_unit #(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         mode,
	input  logic signed [31:0] value,
	input  logic [7:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_data,
	output logic               found,
	output logic [8:0]         element_count,
	output logic [1:0]         status
);

	localparam logic [8:0] CAP_MOD = 9'(CAPACITY % 512);

	logic          cmd_valid;
	logic          cmd_ready;
	dea_pkg::cmd_t cmd;

	dea_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.value    (value),
		.position (position),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	dea_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.found        (found),
		.element_count(element_count),
		.status       (status)
	);

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dea_pkg::STATUS_FULL) |-> element_count == CAP_MOD)
		else $error("full status with count below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dea_pkg::STATUS_EMPTY) |-> element_count == 9'd0)
		else $error("empty status with nonzero count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == dea_pkg::STATUS_OK)
		else $error("found flag with error status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != dea_pkg::STATUS_OK) |-> read_data == 32'sd0)
		else $error("read data nonzero on error status");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CAPACITY     = 256;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 20;
	localparam int REPORT_LIMIT = 10;
	localparam int DW           = dea_pkg::DATA_W;
	localparam int PW           = dea_pkg::POS_W;
	localparam int CW           = dea_pkg::COUNT_W;

	localparam logic [3:0] MODE_FIRST_UNUSED = 4'd9;
	localparam logic [3:0] MODE_LAST_UNUSED  = 4'd15;

	typedef struct packed {
		logic [DW-1:0] read_data;
		logic          found;
		logic [CW-1:0] element_count;
		logic [1:0]    status;
	} store_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [3:0]         mode      = '0;
	logic signed [31:0] value     = '0;
	logic [7:0]         position  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] read_data;
	logic               found;
	logic [8:0]         element_count;
	logic [1:0]         status;

	double_ended_array_store_unit #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.found(found),
		.element_count(element_count),
		.status(status)
	);

	// shadow copy of the deque contents
	logic [DW-1:0] shadow_mem [CAPACITY];
	logic [PW-1:0] shadow_front = '0;
	logic [CW-1:0] shadow_count = '0;

	store_result_t expected_q [$];
	int failures      = 0;
	int idle_cycles   = 0;
	int burst_left    = 0;
	int pattern_age   = 0;
	logic [7:0] ready_pattern = 8'hFF;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic store_result_t apply_op(input logic [3:0] op,
			input logic [DW-1:0] val, input logic [PW-1:0] pos);
		store_result_t r;
		logic [PW-1:0] slot;
		int i;
		r = '0;
		r.status = dea_pkg::STATUS_OK;
		case (op)
		dea_pkg::MODE_ADD_LAST: begin
			if (shadow_count >= CAPACITY) begin
				r.status = dea_pkg::STATUS_FULL;
			end else begin
				slot = shadow_front + shadow_count[PW-1:0];
				shadow_mem[slot] = val;
				shadow_count = shadow_count + 1'b1;
			end
		end
		dea_pkg::MODE_ADD_FIRST: begin
			if (shadow_count >= CAPACITY) begin
				r.status = dea_pkg::STATUS_FULL;
			end else begin
				shadow_front = shadow_front - 1'b1;
				shadow_mem[shadow_front] = val;
				shadow_count = shadow_count + 1'b1;
			end
		end
		dea_pkg::MODE_REMOVE_LAST: begin
			if (shadow_count == 0) begin
				r.status = dea_pkg::STATUS_EMPTY;
			end else begin
				shadow_count = shadow_count - 1'b1;
			end
		end
		dea_pkg::MODE_REMOVE_FIRST: begin
			if (shadow_count == 0) begin
				r.status = dea_pkg::STATUS_EMPTY;
			end else begin
				shadow_front = shadow_front + 1'b1;
				shadow_count = shadow_count - 1'b1;
			end
		end
		dea_pkg::MODE_GET: begin
			if ({1'b0, pos} >= shadow_count) begin
				r.status = dea_pkg::STATUS_RANGE;
			end else begin
				slot = shadow_front + pos;
				r.read_data = shadow_mem[slot];
			end
		end
		dea_pkg::MODE_SET: begin
			if ({1'b0, pos} >= shadow_count) begin
				r.status = dea_pkg::STATUS_RANGE;
			end else begin
				slot = shadow_front + pos;
				shadow_mem[slot] = val;
			end
		end
		dea_pkg::MODE_CONTAINS: begin
			for (i = 0; i < shadow_count; i++) begin
				slot = shadow_front + PW'(i);
				if (shadow_mem[slot] == val)
					r.found = 1'b1;
			end
		end
		dea_pkg::MODE_GET_FIRST: begin
			if (shadow_count == 0) begin
				r.status = dea_pkg::STATUS_EMPTY;
			end else begin
				r.read_data = shadow_mem[shadow_front];
			end
		end
		dea_pkg::MODE_GET_LAST: begin
			if (shadow_count == 0) begin
				r.status = dea_pkg::STATUS_EMPTY;
			end else begin
				// a full store wraps back to the slot before the front
				slot = shadow_front + shadow_count[PW-1:0] - 1'b1;
				r.read_data = shadow_mem[slot];
			end
		end
		default: begin
		end
		endcase
		r.element_count = shadow_count;
		return r;
	endfunction

	function automatic logic [DW-1:0] random_word();
		int r;
		r = $urandom_range(0, 9);
		case (r)
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		// narrow range so that duplicates show up in the store
		4, 5: return DW'($urandom_range(0, 15));
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [PW-1:0] random_position();
		int r;
		r = $urandom_range(0, 7);
		if (r < 5 && shadow_count != 0)
			return PW'($urandom_range(0, shadow_count - 1));
		if (r == 5)
			return shadow_count[PW-1:0];
		return PW'($urandom);
	endfunction

	task automatic send_op(input logic [3:0] op, input logic [DW-1:0] val,
			input logic [PW-1:0] pos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		mode     <= op;
		value    <= val;
		position <= pos;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(apply_op(op, val, pos));
	endtask

	// hold the sender off until every outstanding result is back
	task automatic drain_results;
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_store;
		send_op(dea_pkg::MODE_REMOVE_LAST, '0, '0);
		send_op(dea_pkg::MODE_REMOVE_FIRST, '0, '0);
		send_op(dea_pkg::MODE_GET_FIRST, '0, '0);
		send_op(dea_pkg::MODE_GET_LAST, '0, '0);
		send_op(dea_pkg::MODE_GET, '0, '0);
		send_op(dea_pkg::MODE_SET, 32'hFFFF_FFFF, 8'hFF);
		send_op(dea_pkg::MODE_CONTAINS, '0, '0);
		send_op(MODE_FIRST_UNUSED, 32'hFFFF_FFFF, 8'hFF);
		send_op(MODE_LAST_UNUSED, 32'h8000_0000, 8'h80);
	endtask

	task automatic test_basic_ops;
		send_op(dea_pkg::MODE_ADD_LAST, 32'h7FFF_FFFF, '0);
		send_op(dea_pkg::MODE_ADD_FIRST, 32'h8000_0000, '0);
		send_op(dea_pkg::MODE_ADD_LAST, 32'hFFFF_FFFF, '0);
		send_op(dea_pkg::MODE_ADD_FIRST, 32'h0000_0000, '0);
		send_op(dea_pkg::MODE_GET, '0, 8'd0);
		send_op(dea_pkg::MODE_GET, '0, 8'd3);
		send_op(dea_pkg::MODE_GET, '0, 8'd4);
		send_op(dea_pkg::MODE_GET, '0, 8'hFF);
		send_op(dea_pkg::MODE_SET, 32'h1234_5678, 8'd1);
		send_op(dea_pkg::MODE_SET, 32'h5555_AAAA, 8'd4);
		send_op(dea_pkg::MODE_GET, '0, 8'd1);
		send_op(dea_pkg::MODE_GET_FIRST, '0, '0);
		send_op(dea_pkg::MODE_GET_LAST, '0, '0);
		send_op(dea_pkg::MODE_CONTAINS, 32'h7FFF_FFFF, '0);
		send_op(dea_pkg::MODE_CONTAINS, 32'h0000_0037, '0);
		send_op(dea_pkg::MODE_REMOVE_FIRST, '0, '0);
		send_op(dea_pkg::MODE_REMOVE_LAST, '0, '0);
		send_op(dea_pkg::MODE_GET_FIRST, '0, '0);
		send_op(dea_pkg::MODE_GET_LAST, '0, '0);
	endtask

	task automatic test_fill_to_capacity;
		logic [PW-1:0] slot;
		while (shadow_count < CAPACITY)
			send_op($urandom_range(0, 1) ? dea_pkg::MODE_ADD_FIRST : dea_pkg::MODE_ADD_LAST,
				random_word(), PW'($urandom));
		send_op(dea_pkg::MODE_ADD_LAST, random_word(), '0);
		send_op(dea_pkg::MODE_ADD_FIRST, random_word(), '0);
		send_op(dea_pkg::MODE_GET, '0, 8'hFF);
		send_op(dea_pkg::MODE_SET, 32'hA5A5_5A5A, 8'hFF);
		send_op(dea_pkg::MODE_GET_LAST, '0, '0);
		send_op(dea_pkg::MODE_GET_FIRST, '0, '0);
		// the last element lies at the far end of a scan across the whole store
		slot = shadow_front - 1'b1;
		send_op(dea_pkg::MODE_CONTAINS, shadow_mem[slot] ^ 32'h0000_0001, '0);
		send_op(dea_pkg::MODE_CONTAINS, shadow_mem[slot], '0);
		while (shadow_count > CAPACITY / 2)
			send_op($urandom_range(0, 1) ? dea_pkg::MODE_REMOVE_FIRST
				: dea_pkg::MODE_REMOVE_LAST, random_word(), PW'($urandom));
	endtask

	task automatic run_random_phase(input int items, input int add_pct);
		logic [3:0] op;
		logic [DW-1:0] val;
		logic [PW-1:0] pos;
		logic [PW-1:0] slot;
		int r;
		repeat (items) begin
			r = $urandom_range(0, 99);
			val = random_word();
			pos = random_position();
			if (r < add_pct) begin
				op = $urandom_range(0, 1) ? dea_pkg::MODE_ADD_FIRST : dea_pkg::MODE_ADD_LAST;
			end else if (r < 60) begin
				op = $urandom_range(0, 1) ? dea_pkg::MODE_REMOVE_FIRST
					: dea_pkg::MODE_REMOVE_LAST;
			end else if (r < 70) begin
				op = dea_pkg::MODE_GET;
			end else if (r < 78) begin
				op = dea_pkg::MODE_SET;
			end else if (r < 86) begin
				op = dea_pkg::MODE_CONTAINS;
				// mostly search for something that is actually stored
				if (shadow_count != 0 && $urandom_range(0, 4) < 3) begin
					slot = shadow_front + PW'($urandom_range(0, shadow_count - 1));
					val = shadow_mem[slot];
				end
			end else if (r < 91) begin
				op = dea_pkg::MODE_GET_FIRST;
			end else if (r < 96) begin
				op = dea_pkg::MODE_GET_LAST;
			end else begin
				op = 4'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
			end
			send_op(op, val, pos);
		end
	endtask

	task automatic test_random_traffic;
		run_random_phase(150, 30);
		drain_results();
		run_random_phase(200, 58);
		drain_results();
		run_random_phase(100, 30);
		run_random_phase(150, 5);
	endtask

	// result checker
	always @(posedge clk) begin
		store_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: unexpected result data %h found %b count %0d status %0d",
						$time, read_data, found, element_count, status);
			end else begin
				want = expected_q.pop_front();
				if (read_data !== want.read_data || found !== want.found ||
						element_count !== want.element_count || status !== want.status) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("%0t: mismatch exp data %h found %b count %0d status %0d",
							$time, want.read_data, want.found, want.element_count,
							want.status);
						$display("%0t:          got data %h found %b count %0d status %0d",
							$time, read_data, found, element_count, status);
					end
				end
			end
		end
	end

	// receiver back-pressure: rotating pattern, reloaded now and then
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age <= $urandom_range(20, 80);
			ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		end else begin
			pattern_age <= pattern_age - 1;
			ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
		end
		out_ready <= ready_pattern[0];
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("double_ended_array_store_unit verification failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_basic_ops();
		test_fill_to_capacity();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && expected_q.size() == 0)
			$display("double_ended_array_store_unit verification clean");
		else
			$display("double_ended_array_store_unit verification failed");
		$finish;
	end

endmodule
